/* hw/rtl/smq_alu_pkg.sv */
// Package for the sign-magnitude quantized ALU: operation codes and default sizes.
// Used by sign_magnitude_quantized_alu; depends on nothing else.
package smq_alu_pkg;

    localparam int DEF_WORD_BITS  = 11;
    localparam int DEF_FULL_SCALE = 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

endpackage

/* hw/rtl/sign_magnitude_quantized_alu.sv */
// Sign-magnitude quantized ALU, deeply pipelined, one word per cycle if no stall.
// Depends on smq_alu_pkg (operation codes, default sizes).
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   i_s_axis_tvalid/tready    req_type, operand_a, operand_b
// m_axis    out  o_m_axis_tvalid/tready    result_code, saturated
//
// Stages: A, B, divider stages, output; one word per cycle if the output accepts.
// The depth is set by the restoring divider: one quotient bit per stage.
// Add, sub, mul and div all go through the same divider (mul divides by 2*max).
// Reset clears the valid bits only; no clearing pass.
// Each stage holds when its successor is full and held, so bubbles collapse and
// a stalled output still lets new words fill the empty stages behind it.
module sign_magnitude_quantized_alu
    import smq_alu_pkg::*;
#(
    parameter int WORD_BITS  = DEF_WORD_BITS,
    parameter int FULL_SCALE = DEF_FULL_SCALE,
    localparam int IN_TW  = ((2 + 2 * WORD_BITS + 7) / 8) * 8,
    localparam int OUT_TW = ((WORD_BITS + 1 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [1:0] req_type, [WB+1:2] operand_a, [2WB+1:WB+2] operand_b
    input  logic [IN_TW-1:0]  i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [WB-1:0] result_code, [WB] saturated, rest zero
    output logic [OUT_TW-1:0] o_m_axis_tdata
);

    localparam int MAG_W   = WORD_BITS - 1;
    localparam int MAG_MAX = (1 << MAG_W) - 1;
    localparam int FS_LG   = $clog2(FULL_SCALE);
    localparam int PROD_W  = 2 * MAG_W;
    localparam int SUM_W   = MAG_W + 2;
    localparam int N_W     = 2 * MAG_W + FS_LG + 3;
    localparam int D_W     = MAG_W + FS_LG + 2;

    localparam logic [N_W-1:0] K_MUL  = N_W'(2 * FULL_SCALE);
    localparam logic [N_W-1:0] K_MMAX = N_W'(MAG_MAX);
    localparam logic [N_W-1:0] K_FS   = N_W'(FULL_SCALE);
    localparam logic [D_W-1:0] K_DFS  = D_W'(2 * FULL_SCALE);
    localparam logic [D_W-1:0] K_DMUL = D_W'(2 * MAG_MAX);

    // ---------------- handshake enables ----------------
    logic             en_a, en_b, en_out;
    logic [MAG_W:0]   en_dv;

    // ---------------- stage A: input word ----------------
    logic                 r_a_v;
    t_op                  r_a_op;
    logic [WORD_BITS-1:0] r_a_a, r_a_b;

    assign en_a            = !r_a_v || en_b;
    assign o_s_axis_tready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= i_s_axis_tvalid;
        end
        if (en_a && i_s_axis_tvalid) begin
            r_a_op <= t_op'(i_s_axis_tdata[1:0]);
            r_a_a  <= i_s_axis_tdata[WORD_BITS+1:2];
            r_a_b  <= i_s_axis_tdata[2*WORD_BITS+1:WORD_BITS+2];
        end
    end

    logic                   a_sa, a_sb, a_tb_neg, a_neg, a_dz;
    logic [MAG_W-1:0]       a_ma, a_mb;
    logic signed [SUM_W-1:0] a_ta, a_tb, a_sum, a_abs;
    logic [PROD_W-1:0]      a_prod, a_scl;

    always_comb begin
        a_sa     = r_a_a[MAG_W];
        a_sb     = r_a_b[MAG_W];
        a_ma     = r_a_a[MAG_W-1:0];
        a_mb     = r_a_b[MAG_W-1:0];
        a_tb_neg = a_sb ^ (r_a_op == OP_SUB);
        a_ta     = a_sa ? -$signed({2'b00, a_ma}) : $signed({2'b00, a_ma});
        a_tb     = a_tb_neg ? -$signed({2'b00, a_mb}) : $signed({2'b00, a_mb});
        a_sum    = a_ta + a_tb;
        a_abs    = a_sum[SUM_W-1] ? -a_sum : a_sum;
        a_prod   = PROD_W'(a_ma) * PROD_W'(a_mb);
        a_scl    = PROD_W'(MAG_MAX) * PROD_W'(a_ma);
        a_dz     = (r_a_op == OP_DIV) && (a_mb == '0);
        case (r_a_op)
            OP_ADD, OP_SUB: a_neg = a_sum[SUM_W-1];
            OP_MUL:         a_neg = (a_sa ^ a_sb) && (a_ma != '0) && (a_mb != '0);
            OP_DIV:         a_neg = (a_sa ^ a_sb) && (a_ma != '0);
            default:        a_neg = 1'b0;
        endcase
    end

    // ---------------- stage B: products, sum ----------------
    logic               r_b_v, r_b_neg, r_b_dz;
    t_op                r_b_op;
    logic [MAG_W:0]     r_b_add;
    logic [PROD_W-1:0]  r_b_prod, r_b_scl;
    logic [MAG_W-1:0]   r_b_mb;

    assign en_b = !r_b_v || en_dv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
        if (en_b && r_a_v) begin
            r_b_op   <= r_a_op;
            r_b_neg  <= a_neg;
            r_b_dz   <= a_dz;
            r_b_add  <= a_abs[MAG_W:0];
            r_b_prod <= a_prod;
            r_b_scl  <= a_scl;
            r_b_mb   <= a_mb;
        end
    end

    // Every op becomes floor(n / d); rounding is folded into n.
    logic [N_W-1:0] b_n, b_dtop;
    logic [D_W-1:0] b_d;
    logic           b_ovf;

    always_comb begin
        case (r_b_op)
            OP_ADD, OP_SUB: begin
                b_n = N_W'(r_b_add);
                b_d = D_W'(1);
            end
            OP_MUL: begin
                b_n = K_MUL * N_W'(r_b_prod) + K_MMAX;
                b_d = K_DMUL;
            end
            OP_DIV: begin
                b_n = (N_W'(r_b_scl) << 1) + K_FS * N_W'(r_b_mb);
                b_d = K_DFS * D_W'(r_b_mb);
            end
            default: begin
                b_n = '0;
                b_d = D_W'(1);
            end
        endcase
        b_dtop = N_W'(b_d) << MAG_W;
        // quotient above max iff n >= d * 2^MAG_W; x/0 saturates iff x nonzero
        b_ovf  = r_b_dz ? (b_n != '0) : (b_n >= b_dtop);
    end

    // ---------------- divider: stage 0 loaded, one bit per stage ----------------
    logic             r_dv_v   [0:MAG_W];
    logic             r_dv_ovf [0:MAG_W];
    logic             r_dv_dz  [0:MAG_W];
    logic             r_dv_neg [0:MAG_W];
    logic [N_W-1:0]   r_dv_rem [0:MAG_W];
    logic [D_W-1:0]   r_dv_d   [0:MAG_W];
    logic [MAG_W-1:0] r_dv_q   [0:MAG_W];

    assign en_dv[MAG_W] = !r_dv_v[MAG_W] || en_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en_dv[0]) begin
            r_dv_v[0] <= r_b_v;
        end
        if (en_dv[0] && r_b_v) begin
            r_dv_ovf[0] <= b_ovf;
            r_dv_dz[0]  <= r_b_dz;
            r_dv_neg[0] <= r_b_neg;
            r_dv_rem[0] <= b_n;
            r_dv_d[0]   <= b_d;
            r_dv_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < MAG_W; j++) begin : g_div
        localparam int SH = MAG_W - 1 - j;
        logic [N_W-1:0]   dsh;
        logic             take;
        logic [MAG_W-1:0] qbit;

        assign en_dv[j] = !r_dv_v[j] || en_dv[j+1];
        assign dsh      = N_W'(r_dv_d[j]) << SH;
        assign take     = r_dv_rem[j] >= dsh;
        assign qbit     = MAG_W'(take) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (en_dv[j+1]) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
            if (en_dv[j+1] && r_dv_v[j]) begin
                r_dv_ovf[j+1] <= r_dv_ovf[j];
                r_dv_dz[j+1]  <= r_dv_dz[j];
                r_dv_neg[j+1] <= r_dv_neg[j];
                r_dv_d[j+1]   <= r_dv_d[j];
                r_dv_rem[j+1] <= take ? r_dv_rem[j] - dsh : r_dv_rem[j];
                r_dv_q[j+1]   <= r_dv_q[j] | qbit;
            end
        end
    end

    // ---------------- output register ----------------
    logic                 r_out_v, r_out_sat;
    logic [WORD_BITS-1:0] r_out_code;
    logic [MAG_W-1:0]     o_mag;

    assign en_out = !r_out_v || i_m_axis_tready;

    always_comb begin
        if (r_dv_ovf[MAG_W]) begin
            o_mag = MAG_W'(MAG_MAX);
        end else if (r_dv_dz[MAG_W]) begin
            o_mag = '0;
        end else begin
            o_mag = r_dv_q[MAG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_dv_v[MAG_W];
        end
        if (en_out && r_dv_v[MAG_W]) begin
            r_out_code <= {r_dv_neg[MAG_W], o_mag};
            r_out_sat  <= r_dv_ovf[MAG_W];
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = OUT_TW'({r_out_sat, r_out_code});

`ifndef NO_ASSERTIONS
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_sat) |-> (r_out_code[MAG_W-1:0] == MAG_W'(MAG_MAX)))
        else $error("saturated word without full-scale magnitude");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input held off while output is free");

    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[MAG_W] && !r_dv_ovf[MAG_W] && !r_dv_dz[MAG_W])
            |-> (r_dv_rem[MAG_W] < N_W'(r_dv_d[MAG_W])))
        else $error("divider remainder not below divisor");
`endif

endmodule
